/* rtl/vas_pkg.sv */
// Package for the afterimage streak filter: widths, row layout, register map
// and the per-pixel reduce/expand helpers. No dependencies.
`default_nettype none

package vas_pkg;

    localparam int PLANE_COUNT          = 32;
    localparam int PLANE_W              = $clog2(PLANE_COUNT);
    localparam int DEF_MAX_FRAME_PIXELS = 16384;

    localparam int CH_COUNT = 4;
    localparam int CH_W     = 8;
    localparam int PIX_W    = CH_COUNT * CH_W;
    localparam int STORE_W  = 6;                   // widest stored channel value
    localparam int ENTRY_W  = CH_COUNT * STORE_W;  // one plane at one position

    // streak: 8 planes, stride 4; feedback: 4 planes, stride 8
    localparam int STREAK_TERMS   = 8;
    localparam int FEEDBACK_TERMS = 4;

    // register map
    localparam int          ADDR_W             = 3;
    localparam int          FRAME_W            = 15;
    localparam logic        REG_FEEDBACK_MODE  = 1'b0;
    localparam logic        REG_FRAME_PIXELS   = 1'b1;
    localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST = 15'd16384;

    typedef logic [PIX_W-1:0]   t_pixel;
    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [PLANE_COUNT-1:0][ENTRY_W-1:0] t_row;

    // input pixel -> stored entry: top 5 bits (streak) or top 6 bits (feedback)
    function automatic t_entry reduce_pixel(t_pixel pix, logic fb);
        t_entry e;
        for (int c = 0; c < CH_COUNT; c++) begin
            e[c*STORE_W +: STORE_W] = fb ? pix[c*CH_W+2 +: STORE_W]
                                         : {1'b0, pix[c*CH_W+3 +: STORE_W-1]};
        end
        return e;
    endfunction

    // stored entry -> 32-bit word, channel values in the low bits of each byte
    function automatic t_pixel expand_entry(t_entry e);
        t_pixel p;
        p = '0;
        for (int c = 0; c < CH_COUNT; c++) begin
            p[c*CH_W +: STORE_W] = e[c*STORE_W +: STORE_W];
        end
        return p;
    endfunction

    // output word -> feedback entry, top 6 bits of each byte
    function automatic t_entry fold_sum(t_pixel s);
        t_entry e;
        for (int c = 0; c < CH_COUNT; c++) begin
            e[c*STORE_W +: STORE_W] = s[c*CH_W+2 +: STORE_W];
        end
        return e;
    endfunction

endpackage

`default_nettype wire

/* rtl/vas_if.sv */
// Pixel stream channels (valid/ready) for the afterimage streak filter.
// Depends on vas_pkg.
`default_nettype none

interface vas_pix_in_if import vas_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pixel pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface vas_pix_out_if import vas_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pixel pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

/* rtl/video_afterimage_streak.sv */
// Top level of the afterimage streak filter: plane history memory, pipeline
// and APB register port. Depends on vas_pkg and the channels in vas_if.
`default_nettype none

// Afterimage streak filter. Takes one packed RGBA-style pixel word per clock
// while ready and returns one word per pixel, in order. All 32 history planes
// for one pixel position sit side by side in one 768-bit memory row, so each
// pixel costs exactly one row read and one row write: sustained rate is one
// word per clock, set by that single read/write port pair. A pixel is read at
// accept, combined and written back in the next stage; a pixel at the same
// position right behind it takes the written row from a bypass register. After
// reset the memory is swept to zero, one row per clock; the input is not ready
// during that sweep (register writes are taken as usual). The user must write
// feedback_mode and frame_pixels through the APB port only while the stream
// is idle; the block does not enforce it.
module video_afterimage_streak
    import vas_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    vas_pix_in_if.sink               i_pix,
    vas_pix_out_if.source            o_pix,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    localparam int AW = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
    localparam int EW = (AW + 1 > FRAME_W) ? AW + 1 : FRAME_W;

    // plane history, one row per pixel position
    t_row r_mem [MAX_FRAME_PIXELS];

    // clear sweep
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // registers
    logic               r_mode;
    logic [FRAME_W-1:0] r_frame_pixels;

    // frame position
    logic [AW-1:0]      r_pos;
    logic [PLANE_W-1:0] r_plane;

    // stage 1: row read back, pixel combined
    logic               r_s1_valid;
    t_pixel             r_s1_pix;
    logic [AW-1:0]      r_s1_pos;
    logic [PLANE_W-1:0] r_s1_plane;
    logic               r_s1_mode;
    t_row               r_rd_row;
    logic               r_fwd_hit;
    t_row               r_fwd_row;

    // output word
    logic   r_out_valid;
    t_pixel r_out_pix;

    logic   in_fire;
    logic   s1_adv;
    logic   cfg_wr;
    logic   frame_last;
    logic [EW-1:0] eff_frame;

    t_row   s1_row;
    t_row   s1_new_row;
    t_pixel s1_sum;
    t_pixel s1_term [STREAK_TERMS];
    logic [PLANE_W-1:0] s1_idx [STREAK_TERMS];

    // ---------------- handshakes ----------------
    assign s1_adv        = r_s1_valid && (!r_out_valid || o_pix.ready);
    assign i_pix.ready   = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_fire       = i_pix.valid && i_pix.ready;
    assign o_pix.valid   = r_out_valid;
    assign o_pix.pixel_out = r_out_pix;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= 1'b0;
            r_frame_pixels <= FRAME_PIXELS_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FEEDBACK_MODE: r_mode         <= pwdata[0];
                REG_FRAME_PIXELS:  r_frame_pixels <= pwdata[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FEEDBACK_MODE: prdata = {31'd0, r_mode};
            REG_FRAME_PIXELS:  prdata = {{(32-FRAME_W){1'b0}}, r_frame_pixels};
            default:           prdata = '0;
        endcase
    end

    // ---------------- frame position ----------------
    // frame size clamped to 1..MAX_FRAME_PIXELS
    always_comb begin
        eff_frame = EW'(r_frame_pixels);
        if (eff_frame == '0) begin
            eff_frame = EW'(1);
        end
        if (eff_frame > EW'(MAX_FRAME_PIXELS)) begin
            eff_frame = EW'(MAX_FRAME_PIXELS);
        end
    end

    assign frame_last = (EW'(r_pos) + EW'(1)) >= eff_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_plane <= '0;
        end else if (in_fire) begin
            if (frame_last) begin
                r_pos   <= '0;
                r_plane <= r_plane + PLANE_W'(1);   // wraps over all planes
            end else begin
                r_pos   <= r_pos + AW'(1);
            end
        end
    end

    // ---------------- clear sweep ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(MAX_FRAME_PIXELS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // ---------------- memory ----------------
    // read at accept, write when stage 1 retires; read sees the old row
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (s1_adv) begin
            r_mem[r_s1_pos] <= s1_new_row;
        end
        if (in_fire) begin
            r_rd_row <= r_mem[r_pos];
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // payload; bypass when the word ahead writes the row being read
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pix   <= i_pix.pixel_in;
            r_s1_pos   <= r_pos;
            r_s1_plane <= r_plane;
            r_s1_mode  <= r_mode;
            r_fwd_hit  <= s1_adv && (r_s1_pos == r_pos);
            r_fwd_row  <= s1_new_row;
        end
    end

    always_comb begin
        s1_row = r_fwd_hit ? r_fwd_row : r_rd_row;

        // new entry goes in first; it is part of its own sum
        s1_new_row = s1_row;
        s1_new_row[r_s1_plane] = reduce_pixel(r_s1_pix, r_s1_mode);

        // planes congruent to the current one: mod 4 (streak) or mod 8 (feedback)
        for (int k = 0; k < STREAK_TERMS; k++) begin
            if (r_s1_mode) begin
                s1_idx[k] = {2'(k), r_s1_plane[2:0]};
            end else begin
                s1_idx[k] = {3'(k), r_s1_plane[1:0]};
            end
            if (!r_s1_mode || k < FEEDBACK_TERMS) begin
                s1_term[k] = expand_entry(s1_new_row[s1_idx[k]]);
            end else begin
                s1_term[k] = '0;
            end
        end

        // full-word add: mixed-mode history can carry across channels
        s1_sum = ((s1_term[0] + s1_term[1]) + (s1_term[2] + s1_term[3]))
               + ((s1_term[4] + s1_term[5]) + (s1_term[6] + s1_term[7]));

        if (r_s1_mode) begin
            s1_new_row[r_s1_plane] = fold_sum(s1_sum);
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pix <= s1_sum;
        end
    end

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking bench for video_afterimage_streak: random pixel streams and
// register settings against an in-bench plane history predictor.
// Depends on vas_pkg, the channels in vas_if and the RTL top level.
`default_nettype none

module testbench;
    import vas_pkg::*;

    // channel idling modes, one per phase
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle;

    // per-mode reduction of a pixel to its stored form
    localparam t_pixel FB_KEEP_MASK     = 32'hfcfcfcfc;
    localparam t_pixel STREAK_KEEP_MASK = 32'hf8f8f8f8;
    localparam int     FB_SHIFT         = 2;
    localparam int     STREAK_SHIFT     = 3;
    localparam int     FB_STRIDE        = 8;
    localparam int     STREAK_STRIDE    = 4;

    localparam int HOLD_CYCLES   = 400;      // long receiver hold-off
    localparam int DRAIN_CYCLES  = 8;        // pipeline is two deep; some margin
    localparam int LIMIT_CYCLES  = 400000;   // sweep + ~1000 words, stalls, many times over
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_WORDS   = 60;
    localparam int PRESSURE_WORDS = 150;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    vas_pix_in_if  in_ch ();
    vas_pix_out_if out_ch ();

    video_afterimage_streak i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (in_ch),
        .o_pix   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Predictor state: its own copy of the history planes, position, plane
    // and the two registers. bit storage starts at zero, matching reset.
    // ---------------------------------------------------------------------
    bit   [31:0]        plane_hist [PLANE_COUNT][DEF_MAX_FRAME_PIXELS];
    int                 pix_pos    = 0;
    int                 cur_plane  = 0;
    bit                 fb_mode    = 1'b0;
    logic [FRAME_W-1:0] frame_size = FRAME_PIXELS_RST;

    t_pixel pixel_queue[$];      // words waiting to be offered
    t_pixel expected_sums[$];    // output words still owed by the block
    bit     word_taken = 1'b0;   // set at the edge that accepted an input word
    int     fail_count = 0;
    t_idle  idle_mode  = IDLE_NONE;
    bit     hold_arm   = 1'b0;
    int     hold_left  = 0;

    // Store the reduced pixel in the current plane, sum the planes congruent
    // to it (mod 4 streak, mod 8 feedback), fold the sum back in feedback
    // mode, then step the position and wrap the frame.
    function automatic t_pixel predict_sum(t_pixel pix);
        t_pixel keep_mask;
        t_pixel sum;
        int     shift;
        int     stride;
        int     plane;
        int     pos;
        int     base;
        int     last;
        if (fb_mode) begin
            keep_mask = FB_KEEP_MASK;
            shift     = FB_SHIFT;
            stride    = FB_STRIDE;
        end else begin
            keep_mask = STREAK_KEEP_MASK;
            shift     = STREAK_SHIFT;
            stride    = STREAK_STRIDE;
        end
        plane = cur_plane;
        pos   = pix_pos;
        plane_hist[plane][pos] = (pix & keep_mask) >> shift;
        base = plane % stride;
        sum  = '0;
        for (int k = 0; k < PLANE_COUNT / stride; k++) begin
            sum += plane_hist[base + k * stride][pos];
        end
        if (fb_mode) begin
            plane_hist[plane][pos] = (sum & keep_mask) >> shift;
        end
        // size 0 acts as 1, oversize clamps; a shrink mid-frame ends it now
        if (frame_size == 0) begin
            last = 1;
        end else if (frame_size > DEF_MAX_FRAME_PIXELS) begin
            last = DEF_MAX_FRAME_PIXELS;
        end else begin
            last = frame_size;
        end
        if (pos + 1 >= last) begin
            pix_pos   = 0;
            cur_plane = (plane + 1) % PLANE_COUNT;
        end else begin
            pix_pos = pos + 1;
        end
        return sum;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 73;
            IDLE_BOTH:   return $urandom_range(0, 99) < 21;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 73;
            IDLE_BOTH:     return $urandom_range(0, 99) < 21;
            default:       return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Driver: offers the head of pixel_queue at the falling edge and holds
    // it until the monitor reports it taken.
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        bit was_taken;
        was_taken = word_taken;
        if (was_taken) begin
            word_taken = 1'b0;
            void'(pixel_queue.pop_front());
        end
        if (!in_ch.valid || was_taken) begin
            if (i_rst_n && pixel_queue.size() != 0 && !sender_idles()) begin
                in_ch.valid    <= 1'b1;
                in_ch.pixel_in <= pixel_queue[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Long hold-off, counted here so the sender keeps offering meanwhile.
    always @(negedge i_clk) begin
        if (hold_arm) begin
            hold_arm = 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && hold_left == 0 && !receiver_stalls();
    end

    // ---------------------------------------------------------------------
    // Monitor: predicts on each accepted input word, checks each accepted
    // output word against the oldest prediction.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                expected_sums.push_back(predict_sum(in_ch.pixel_in));
                word_taken = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_sums.size() == 0) begin
                    $error("pixel_out: expected nothing, got %h", out_ch.pixel_out);
                    fail_count++;
                end else begin
                    want = expected_sums.pop_front();
                    if (out_ch.pixel_out !== want) begin
                        $error("pixel_out: expected %h, got %h", want, out_ch.pixel_out);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Register port. Leaves psel high so writes can go back to back; the
    // caller drops it once done.
    // ---------------------------------------------------------------------
    task automatic apb_write(logic reg_sel, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (reg_sel == REG_FEEDBACK_MODE) begin
            fb_mode = data[0];
        end else begin
            frame_size = data[FRAME_W-1:0];
        end
    endtask

    // Upper data bits are noise; the block keeps only the register's width.
    task automatic set_config(bit fb, logic [FRAME_W-1:0] frame);
        apb_write(REG_FEEDBACK_MODE, ($urandom & ~32'h1) | 32'(fb));
        apb_write(REG_FRAME_PIXELS, ($urandom & ~32'h7fff) | 32'(frame));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Every word offered and answered, then a margin for the pipeline to empty.
    task automatic wait_drained();
        while (pixel_queue.size() != 0 || expected_sums.size() != 0 || in_ch.valid) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly small frames so the plane index wraps many times; now and then
    // the extremes, zero and the out-of-range sizes.
    function automatic logic [FRAME_W-1:0] pick_frame();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 15'd1;
            2, 3, 4: return 15'($urandom_range(1, 8));
            5, 6:    return 15'($urandom_range(9, 64));
            7:       return 15'(DEF_MAX_FRAME_PIXELS);
            8:       return 15'($urandom_range(DEF_MAX_FRAME_PIXELS + 1, 32767));
            default: return 15'($urandom_range(1, 32767));
        endcase
    endfunction

    task automatic queue_random(int count);
        t_pixel pix;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0:       pix = '0;
                1:       pix = '1;
                2:       pix = {4{8'($urandom_range(0, 255))}};
                default: pix = $urandom;
            endcase
            pixel_queue.push_back(pix);
        end
    endtask

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        t_pixel streak_probe[8];
        t_pixel fb_probe[12];
        t_pixel clamp_probe[4];

        streak_probe = '{
            32'h00000000, 32'hffffffff, 32'h07070707, 32'h08080808,
            32'hf8f8f8f8, 32'h80402010, 32'h01020304, 32'h7f7f7f7f
        };
        fb_probe = '{
            32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
            32'hffffffff, 32'hffffffff, 32'h03030303, 32'h04040404,
            32'hfcfcfcfc, 32'h00000000, 32'h55aa33cc, 32'haa55cc33
        };
        clamp_probe = '{
            32'hffffffff, 32'h10203040, 32'hfedcba98, 32'h00000000
        };

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.pixel_in = '0;
        out_ch.ready   = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: streak mode, full-size frame. The memory sweep
        // after reset holds these off until it is done.
        foreach (streak_probe[i]) pixel_queue.push_back(streak_probe[i]);
        wait_drained();

        // Feedback, size written as zero: acts as one pixel per frame and
        // cuts the big frame short mid-way. Saturated input builds up.
        set_config(1'b1, '0);
        idle_mode = IDLE_BOTH;
        foreach (fb_probe[i]) pixel_queue.push_back(fb_probe[i]);
        wait_drained();

        // Streak again with the largest size the register holds (clamped).
        set_config(1'b0, 15'h7fff);
        idle_mode = IDLE_NONE;
        foreach (clamp_probe[i]) pixel_queue.push_back(clamp_probe[i]);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_config(1'($urandom_range(0, 1)), pick_frame());
            idle_mode = t_idle'(p % 4);
            queue_random(PHASE_WORDS);
            wait_drained();
        end

        // Receiver goes quiet while the sender keeps pushing: the pipeline
        // fills and the input has to stall.
        set_config(1'($urandom_range(0, 1)), 15'($urandom_range(1, 4)));
        idle_mode = IDLE_NONE;
        @(posedge i_clk);
        hold_arm = 1'b1;
        queue_random(PRESSURE_WORDS);
        wait_drained();

        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #(2 * LIMIT_CYCLES);
        $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/vas_pkg.sv
rtl/vas_if.sv
rtl/video_afterimage_streak.sv
test/testbench.sv
